FILE: rtl/svang_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_pkg
// Shared types, widths and constants for the signed vector angle block.
// ----------------------------------------------------------------------------
package svang_pkg;

    // Angle accumulator in degrees * 2^16, signed.
    localparam int ZW          = 25;
    // Result angle in degrees * 2^8, signed.
    localparam int ANGLE_W     = 17;
    localparam int OUT_TW      = ((ANGLE_W + 7) / 8) * 8;
    localparam int FRAC_DROP   = 8;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [ZW-1:0]      Z_QUARTER = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0]      Z_ROUND   = ZW'(128);
    localparam logic [ANGLE_W-1:0]        ANGLE_MAX = ANGLE_W'(46080);
    localparam logic [ANGLE_W-1:0]        ANGLE_NEG_MAX = ANGLE_W'(46079);

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_DEG16 [ATAN_ENTRIES] = '{
        ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
        ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
        ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
        ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
        ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
        ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
    };

    // Flags that ride along with each transaction through the chain
    typedef struct packed {
        logic neg;   // exact cross product is negative
        logic zero;  // one of the two vectors is (0,0)
    } t_side;

endpackage

FILE: rtl/svang_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_front
// Forms cross and dot products, then the pre-rotated CORDIC start vector.
// ----------------------------------------------------------------------------
module svang_front #(
    parameter int COORD_WIDTH = 16,
    parameter int XW          = 35
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_mx,
    input  logic signed [COORD_WIDTH-1:0] i_my,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [svang_pkg::ZW-1:0] o_z,
    output svang_pkg::t_side              o_side
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int WS = (PW > 60) ? (PW - 60) : 0;

    // stage 1: products
    logic                 r_v1;
    logic signed [PW-1:0] r_p1, r_p2, r_d1, r_d2;
    logic                 r_zero1;
    logic                 w_rdy1, w_take1;

    // stage 2: start vector
    logic                           r_v2;
    logic signed [XW-1:0]           r_x, r_y, n_x, n_y;
    logic signed [svang_pkg::ZW-1:0] r_z, n_z;
    svang_pkg::t_side               r_side;
    logic                           w_rdy2, w_take2, w_neg;
    logic signed [PW-1:0]           w_hi, w_lo;
    logic signed [XW-1:0]           w_cross, w_dot;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_take1 = i_valid && w_rdy1;
    assign w_take2 = r_v1 && w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take1) begin
            r_p1    <= PW'(i_bx) * PW'(i_my);
            r_p2    <= PW'(i_by) * PW'(i_mx);
            r_d1    <= PW'(i_bx) * PW'(i_mx);
            r_d2    <= PW'(i_by) * PW'(i_my);
            r_zero1 <= ((i_mx == '0) && (i_my == '0)) || ((i_bx == '0) && (i_by == '0));
        end
    end

    // Order the cross terms so the magnitude never goes negative
    always_comb begin
        w_neg   = (r_p1 < r_p2);
        w_hi    = w_neg ? r_p2 : r_p1;
        w_lo    = w_neg ? r_p1 : r_p2;
        w_cross = XW'(w_hi >>> WS) - XW'(w_lo >>> WS);
        w_dot   = XW'(r_d1 >>> WS) + XW'(r_d2 >>> WS);
        if (w_dot[XW-1]) begin
            // turn by -90 degrees into the right half plane
            n_x = w_cross;
            n_y = -w_dot;
            n_z = svang_pkg::Z_QUARTER;
        end else begin
            n_x = w_dot;
            n_y = w_cross;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take2) begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_side.neg  <= w_neg;
            r_side.zero <= r_zero1;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

FILE: rtl/svang_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svang_cell
// One CORDIC vectoring micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module svang_cell #(
    parameter int XW    = 35,
    parameter int STAGE = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [XW-1:0]            i_x,
    input  logic signed [XW-1:0]            i_y,
    input  logic signed [svang_pkg::ZW-1:0] i_z,
    input  svang_pkg::t_side                i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [XW-1:0]            o_x,
    output logic signed [XW-1:0]            o_y,
    output logic signed [svang_pkg::ZW-1:0] o_z,
    output svang_pkg::t_side                o_side
);

    logic                            r_valid;
    logic signed [XW-1:0]            r_x, r_y, n_x, n_y;
    logic signed [svang_pkg::ZW-1:0] r_z, n_z;
    svang_pkg::t_side                r_side;
    logic signed [XW-1:0]            w_xs, w_ys;
    logic                            w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Rotate toward the x axis; both updates use the old x and y
    always_comb begin
        w_xs = i_x >>> STAGE;
        w_ys = i_y >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + svang_pkg::ATAN_DEG16[STAGE];
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - svang_pkg::ATAN_DEG16[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

FILE: rtl/signed_vector_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_vector_angle_top
// Signed angle from a base vector to a moving vector, degrees * 256.
// ----------------------------------------------------------------------------
// Pipeline: from input transaction to o_m_tvalid the data passes through
//   2 front stages for products and pre-rotation, one cell per micro-rotation
//   and one output register; at most 24 cells are built.
// Throughput: one transaction per cycle while i_m_tready keeps up; every stage has
//   its own valid bit, so bubbles close up while the output waits.
// Reset: i_rst_n synchronous, active low; clears all valid bits, data is kept.
// ----------------------------------------------------------------------------
module signed_vector_angle_top #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // slave side
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // i_s_tdata, from bit 0: moving_x, moving_y, base_x, base_y, zero pad
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    // master side
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // o_m_tdata, from bit 0: angle_deg (17 bits signed), zero pad
    output logic [svang_pkg::OUT_TW-1:0]              o_m_tdata,
    // o_m_tuser, bit 0: zero_vector
    output logic                                      o_m_tuser
);

    // Working widths: products are exact, trimmed only above 60 bits; three
    // guard bits cover the dot sum, the pre-rotation and the CORDIC gain.
    localparam int PW    = 2 * COORD_WIDTH;
    localparam int WS    = (PW > 60) ? (PW - 60) : 0;
    localparam int XW    = PW - WS + 3;
    localparam int NCELL = (CORDIC_STAGES < svang_pkg::ATAN_ENTRIES) ?
                           CORDIC_STAGES : svang_pkg::ATAN_ENTRIES;

    // Chain links: index k feeds cell k, index NCELL feeds the output stage
    logic                            w_valid [0:NCELL];
    logic                            w_ready [0:NCELL];
    logic signed [XW-1:0]            w_x     [0:NCELL];
    logic signed [XW-1:0]            w_y     [0:NCELL];
    logic signed [svang_pkg::ZW-1:0] w_z     [0:NCELL];
    svang_pkg::t_side                w_side  [0:NCELL];

    // Front end: products, then cross magnitude, dot and pre-rotation
    svang_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_mx    (i_s_tdata[COORD_WIDTH-1:0]),
        .i_my    (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_bx    (i_s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .i_by    (i_s_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_side  (w_side[0])
    );

    // Row of micro-rotation cells, one per CORDIC iteration
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        svang_cell #(
            .XW    (XW),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Output stage: clamp, round, saturate, apply sign
    logic                                r_out_valid;
    logic [svang_pkg::ANGLE_W-1:0]       r_angle, n_angle;
    logic                                r_zero;
    logic signed [svang_pkg::ZW-1:0]     w_zpos, w_zrnd;
    logic [svang_pkg::ANGLE_W-1:0]       w_mag;
    logic                                w_take;

    assign w_ready[NCELL] = !r_out_valid || i_m_tready;
    assign w_take         = w_valid[NCELL] && w_ready[NCELL];

    always_comb begin
        // drop a negative accumulator to zero, then round half up
        w_zpos = w_z[NCELL][svang_pkg::ZW-1] ? '0 : w_z[NCELL];
        w_zrnd = w_zpos + svang_pkg::Z_ROUND;
        w_mag  = w_zrnd[svang_pkg::ZW-1:svang_pkg::FRAC_DROP];
        if (w_mag > svang_pkg::ANGLE_MAX) begin
            w_mag = svang_pkg::ANGLE_MAX;
        end
        if (w_side[NCELL].zero) begin
            n_angle = '0;
        end else if (w_side[NCELL].neg) begin
            // keep the result inside (-180,180]
            if (w_mag > svang_pkg::ANGLE_NEG_MAX) begin
                w_mag = svang_pkg::ANGLE_NEG_MAX;
            end
            n_angle = -w_mag;
        end else begin
            n_angle = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NCELL]) begin
            r_out_valid <= w_valid[NCELL];
        end
    end

    // Hold the result until the master side takes the transaction
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_angle <= n_angle;
            r_zero  <= w_side[NCELL].zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = svang_pkg::OUT_TW'(r_angle);
    assign o_m_tuser  = r_zero;

endmodule
